// ===== rtl/swtsm_pkg.sv =====
// Shared types, codes and sizes for the timer slot bank.
// Used by swtsm_cell and software_timer_slot_manager; depends on nothing.
package swtsm_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int TICK_BITS = 32;

  // input kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_INIT    = 3'd1;
  localparam logic [2:0] KIND_START   = 3'd2;
  localparam logic [2:0] KIND_STOP    = 3'd3;
  localparam logic [2:0] KIND_DESTROY = 3'd4;

  // result status codes
  localparam logic [1:0] RS_OK      = 2'd0;
  localparam logic [1:0] RS_INVALID = 2'd1;
  localparam logic [1:0] RS_AGAIN   = 2'd2;

  // slot states
  localparam logic [1:0] SL_FREE = 2'd0;
  localparam logic [1:0] SL_INIT = 2'd1;
  localparam logic [1:0] SL_WAIT = 2'd2;
  localparam logic [1:0] SL_STOP = 2'd3;

  // result kinds
  localparam logic EV_STATUS = 1'b0;
  localparam logic EV_EXPIRY = 1'b1;

  // broadcast from the controller to every slot cell
  typedef struct packed {
    logic                 tick;      // tick transaction accepted this cycle
    logic                 apply;     // command accepted with status ok
    logic [2:0]           kind;
    logic [TICK_BITS-1:0] period;
    logic                 periodic;
  } cell_cmd_t;

endpackage

// ===== rtl/swtsm_cell.sv =====
// One timer slot: state, period, mode, countdown and the expiry flag that
// moves toward slot 0 while results are emitted. Depends on swtsm_pkg.
module swtsm_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swtsm_pkg::cell_cmd_t           cmd,
  input  logic                           sel,      // command addresses this slot
  input  logic                           shift,    // expiry chain advances
  input  logic                           pend_in,  // expiry flag of upper neighbor
  output logic                           pend_r,
  output logic [1:0]                     state_r,
  output logic [swtsm_pkg::TICK_BITS-1:0] period_r
);
  import swtsm_pkg::*;

  logic [TICK_BITS-1:0] cnt_r, cnt_nxt, period_nxt;
  logic [1:0]           state_nxt;
  logic                 mode_r, mode_nxt, pend_nxt;
  logic                 expire;

  // waiting slot at zero or one expires on this tick
  assign expire = (state_r == SL_WAIT) && (cnt_r <= TICK_BITS'(1));

  // next slot contents
  always_comb begin
    cnt_nxt    = cnt_r;
    period_nxt = period_r;
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    if (cmd.tick) begin
      pend_nxt = expire;
      if (state_r == SL_WAIT) begin
        if (!expire) begin
          cnt_nxt = cnt_r - TICK_BITS'(1);
        end else if (mode_r) begin
          cnt_nxt = period_r;
        end else begin
          cnt_nxt   = '0;
          state_nxt = SL_STOP;
        end
      end
    end else if (shift) begin
      pend_nxt = pend_in;
    end else if (cmd.apply && sel) begin
      unique case (cmd.kind)
        KIND_INIT: begin
          period_nxt = cmd.period;
          mode_nxt   = cmd.periodic;
          cnt_nxt    = '0;
          state_nxt  = SL_INIT;
        end
        KIND_START: begin
          cnt_nxt   = period_r;
          state_nxt = SL_WAIT;
        end
        KIND_STOP: begin
          state_nxt = SL_STOP;
        end
        KIND_DESTROY: begin
          state_nxt  = SL_FREE;
          period_nxt = '0;
          cnt_nxt    = '0;
          mode_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      period_r <= '0;
      state_r  <= SL_FREE;
      mode_r   <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      period_r <= period_nxt;
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

// ===== rtl/software_timer_slot_manager.sv =====
// Timer slot bank top level: stream ports, APB register, command decode,
// expiry scan and output register. Depends on swtsm_pkg and swtsm_cell.
//
//   channel | ports                          | transaction
//   --------+--------------------------------+-------------------------------
//   input   | in_tvalid/in_tready/in_tdata   | tick or slot command
//   result  | out_tvalid/out_tready/out_tdata| status or expiry, tlast at end
//   config  | cfg_psel..cfg_prdata           | max_period_ticks at 0x0
//
// A command gives one result into the output register.
// A tick updates all slot cells together, then the expiry flags walk down
// the cell chain one slot a cycle (no walk when nothing expires),
// ending after the highest expired slot; each expiry waits for the output
// register to drain.
// in_tready is low during that walk and while a result is held.
// Synchronous active-low reset: all slots free, register at all ones.
module software_timer_slot_manager (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [3:0] slot, [35:4] period_ticks, [36] periodic
  input  logic [2:0]  in_tuser,   // [2:0] kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] status, [5:2] fired_slot
  output logic        out_tuser,  // [0] event_res
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import swtsm_pkg::*;

  logic [31:0]          max_per_r;
  logic [SLOTS-1:0]     pend_v;
  logic [1:0]           cell_st  [SLOTS];
  logic [TICK_BITS-1:0] cell_per [SLOTS];
  cell_cmd_t            cmd;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic                 out_valid_r, out_event_r, out_last_r;
  logic [1:0]           out_status_r;
  logic [3:0]           out_slot_r;
  logic                 busy, out_space, in_acc, tick_acc, cmd_acc;
  logic                 advance, emit, last_exp;
  logic [2:0]           kind;
  logic [3:0]           slot_in;
  logic [TICK_BITS-1:0] per_in;
  logic                 slot_ok;
  logic [1:0]           sel_st;
  logic [TICK_BITS-1:0] sel_per;
  logic [1:0]           status;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? max_per_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_per_r <= 32'hFFFF_FFFF;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == 1'b0) begin
      max_per_r <= cfg_pwdata;
    end
  end

  // input handshake
  assign kind      = in_tuser;
  assign slot_in   = in_tdata[3:0];
  assign per_in    = in_tdata[35:4];
  assign busy      = |pend_v;
  assign out_space = !out_valid_r || out_tready;
  assign in_tready = !busy && out_space;
  assign in_acc    = in_tvalid && in_tready;
  assign tick_acc  = in_acc && (kind == KIND_TICK);
  assign cmd_acc   = in_acc && (kind != KIND_TICK);

  // addressed slot lookup and command status
  assign slot_ok = ({1'b0, slot_in} < 5'(SLOTS));
  assign sel_st  = cell_st[slot_in[SLOT_W-1:0]];
  assign sel_per = cell_per[slot_in[SLOT_W-1:0]];

  always_comb begin
    status = RS_INVALID;
    if (slot_ok) begin
      unique case (kind)
        KIND_INIT: begin
          if (per_in == '0)          status = RS_INVALID;
          else if (sel_st == SL_WAIT) status = RS_AGAIN;
          else                        status = RS_OK;
        end
        KIND_START: begin
          if (sel_st == SL_FREE || sel_per > max_per_r) status = RS_INVALID;
          else if (sel_st == SL_WAIT)                     status = RS_AGAIN;
          else                                            status = RS_OK;
        end
        KIND_STOP: begin
          status = (sel_st == SL_WAIT) ? RS_OK : RS_AGAIN;
        end
        KIND_DESTROY: begin
          if (sel_st == SL_WAIT)      status = RS_AGAIN;
          else if (sel_st == SL_FREE) status = RS_INVALID;
          else                        status = RS_OK;
        end
        default: status = RS_INVALID;
      endcase
    end
  end

  assign cmd.tick     = tick_acc;
  assign cmd.apply    = cmd_acc && (status == RS_OK);
  assign cmd.kind     = kind;
  assign cmd.period   = per_in;
  assign cmd.periodic = in_tdata[36];

  // expiry scan: head of the chain is slot idx_r
  assign emit     = busy && pend_v[0] && out_space;
  assign advance  = busy && (!pend_v[0] || out_space);
  assign last_exp = (pend_v[SLOTS-1:1] == '0);

  // slot cell chain
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic pend_up;
    if (i == SLOTS - 1) begin : g_top
      assign pend_up = 1'b0;
    end else begin : g_mid
      assign pend_up = pend_v[i+1];
    end
    swtsm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (slot_in[SLOT_W-1:0] == SLOT_W'(i)),
      .shift    (advance),
      .pend_in  (pend_up),
      .pend_r   (pend_v[i]),
      .state_r  (cell_st[i]),
      .period_r (cell_per[i])
    );
  end

  always_comb begin
    idx_nxt = idx_r;
    if (tick_acc)     idx_nxt = '0;
    else if (advance) idx_nxt = idx_r + SLOT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_acc || emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      out_event_r  <= EV_STATUS;
      out_status_r <= status;
      out_slot_r   <= slot_in;
      out_last_r   <= 1'b1;
    end else if (emit) begin
      out_event_r  <= EV_EXPIRY;
      out_status_r <= RS_OK;
      out_slot_r   <= 4'(idx_r);
      out_last_r   <= last_exp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_slot_r, out_status_r};
  assign out_tuser  = out_event_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // no new transaction enters while expiries are still pending
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("input accepted during expiry scan");

  // the final expiry ends the scan
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_exp) |=> !busy) else $error("scan continues after last expiry");

  // the scan never runs past the top slot
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && idx_r == SLOT_W'(SLOTS - 1)) |=> !busy)
    else $error("expiry scan wrapped");

  // a command yields exactly one final status result
  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_acc |=> (out_valid_r && out_event_r == EV_STATUS && out_last_r))
    else $error("command result malformed");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the timer slot bank (software_timer_slot_manager).
// Drives ticks and slot commands on the input stream, predicts status and expiry
// results with an internal slot model; depends on rtl/swtsm_pkg.sv and the RTL.
module testbench;
  import swtsm_pkg::*;

  // codes outside the defined command set
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  // register map
  localparam logic [2:0] CFG_ADDR_MAX_PERIOD = 3'd0;
  // cycles to let a tick scan finish before touching the register
  localparam int SCAN_DRAIN = 24;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [31:0] period;
    logic        periodic;
    logic        typed;     // status below is the typed-in expectation
    logic [1:0]  status;
  } stim_row_t;

  typedef struct packed {
    logic       ev;
    logic [1:0] status;
    logic [3:0] slot;
    logic       last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // slot model
  logic [31:0] slot_count  [SLOTS];
  logic [31:0] slot_period [SLOTS];
  logic        slot_repeat [SLOTS];
  logic [1:0]  slot_phase  [SLOTS];
  logic [31:0] max_period = 32'hFFFF_FFFF;

  timer_result_t expected_events[$];
  stim_row_t     directed_rows [25];
  int            fail_count = 0;
  bit            in_no_gaps = 1'b0;
  bit            out_no_stalls = 1'b0;

  software_timer_slot_manager u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [3:0] slot, [35:4] period_ticks, [36] periodic
    .in_tuser    (in_tuser),    // [2:0] kind
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // [1:0] status, [5:2] fired_slot
    .out_tuser   (out_tuser),   // [0] event_res
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Apply one accepted transaction to the slot model, queue the results it causes
  task automatic predict_timer_results(input stim_row_t row);
    logic [1:0]       rs;
    logic [SLOTS-1:0] due;
    int               top;
    if (row.kind != KIND_TICK) begin
      rs = RS_INVALID;
      case (row.kind)
        KIND_INIT: begin
          if (row.period == '0) rs = RS_INVALID;
          else if (slot_phase[row.slot] == SL_WAIT) rs = RS_AGAIN;
          else begin
            slot_period[row.slot] = row.period;
            slot_repeat[row.slot] = row.periodic;
            slot_count[row.slot]  = '0;
            slot_phase[row.slot]  = SL_INIT;
            rs = RS_OK;
          end
        end
        KIND_START: begin
          if (slot_phase[row.slot] == SL_FREE || slot_period[row.slot] > max_period)
            rs = RS_INVALID;
          else if (slot_phase[row.slot] == SL_WAIT) rs = RS_AGAIN;
          else begin
            slot_count[row.slot] = slot_period[row.slot];
            slot_phase[row.slot] = SL_WAIT;
            rs = RS_OK;
          end
        end
        KIND_STOP: begin
          if (slot_phase[row.slot] != SL_WAIT) rs = RS_AGAIN;
          else begin
            slot_phase[row.slot] = SL_STOP;
            rs = RS_OK;
          end
        end
        KIND_DESTROY: begin
          if (slot_phase[row.slot] == SL_WAIT) rs = RS_AGAIN;
          else if (slot_phase[row.slot] == SL_FREE) rs = RS_INVALID;
          else begin
            slot_phase[row.slot]  = SL_FREE;
            slot_period[row.slot] = '0;
            slot_count[row.slot]  = '0;
            slot_repeat[row.slot] = 1'b0;
            rs = RS_OK;
          end
        end
        default: rs = RS_INVALID;
      endcase
      if (row.typed) rs = row.status;
      expected_events.push_back({EV_STATUS, rs, row.slot, 1'b1});
    end else begin
      // find the expiring slots first so the highest one carries tlast
      due = '0;
      top = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_phase[i] == SL_WAIT && slot_count[i] <= 32'd1) begin
          due[i] = 1'b1;
          top = i;
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_phase[i] == SL_WAIT) begin
          if (!due[i]) slot_count[i] = slot_count[i] - 32'd1;
          else begin
            if (slot_repeat[i]) slot_count[i] = slot_period[i];
            else begin
              slot_count[i] = '0;
              slot_phase[i] = SL_STOP;
            end
            expected_events.push_back({EV_EXPIRY, RS_OK, i[3:0], i == top});
          end
        end
      end
    end
  endtask

  // One input transaction with a random lead-in gap; returns at the accepting edge
  task automatic send_item(input stim_row_t row);
    int gap;
    gap = in_no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.kind;
    in_tdata  <= {3'b000, row.periodic, row.period, row.slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_timer_results(row);
  endtask

  // Stop sending, drain every expected result, then let any scan settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    for (int k = 0; k < 20000 && expected_events.size() != 0; k++) @(posedge clk);
    repeat (SCAN_DRAIN) @(posedge clk);
  endtask

  // Register write followed by a read-back
  task automatic write_max_period(input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_ADDR_MAX_PERIOD;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    max_period = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_psel <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== value) begin
      fail_count++;
      if (fail_count <= 10)
        $display("max_period_ticks readback: expected %h, got %h", value, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Random traffic: mostly ticks and init/start, with most commands on a few busy slots
  task automatic run_random_phase(input int count);
    stim_row_t row;
    int        pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) row.kind = KIND_TICK;
      else if (pick < 58) row.kind = KIND_INIT;
      else if (pick < 78) row.kind = KIND_START;
      else if (pick < 88) row.kind = KIND_STOP;
      else if (pick < 96) row.kind = KIND_DESTROY;
      else row.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      row.slot = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 5))
                                              : 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 60) row.period = $urandom_range(1, 4);
      else if (pick < 75) row.period = $urandom_range(5, 30);
      else if (pick < 85) row.period = '0;
      else row.period = $urandom;
      row.periodic = 1'($urandom_range(0, 1));
      row.typed    = 1'b0;
      row.status   = RS_OK;
      send_item(row);
    end
  endtask

  // Result sink: random stalls, compare each transaction with the oldest expectation
  initial begin : result_sink
    int            stall;
    timer_result_t got;
    timer_result_t want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_no_stalls ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = {out_tuser, out_tdata[1:0], out_tdata[5:2], out_tlast};
      if (expected_events.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: event %b status %0d slot %0d last %b",
                   got.ev, got.status, got.slot, got.last);
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"result mismatch: expected event %b status %0d slot %0d last %b,",
                      " got event %b status %0d slot %0d last %b"},
                     want.ev, want.status, want.slot, want.last,
                     got.ev, got.status, got.slot, got.last);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #3000000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : main_seq
    logic [31:0] phase_max [4];
    for (int i = 0; i < SLOTS; i++) begin
      slot_count[i]  = '0;
      slot_period[i] = '0;
      slot_repeat[i] = 1'b0;
      slot_phase[i]  = SL_FREE;
    end
    // fields: kind, slot, period, periodic, typed, status
    directed_rows[0]  = {KIND_START,     4'd0,  32'd0,          1'b0, 1'b1, RS_INVALID};
    directed_rows[1]  = {KIND_STOP,      4'd0,  32'd0,          1'b0, 1'b1, RS_AGAIN};
    directed_rows[2]  = {KIND_DESTROY,   4'd15, 32'd0,          1'b0, 1'b1, RS_INVALID};
    directed_rows[3]  = {KIND_INIT,      4'd0,  32'd0,          1'b1, 1'b1, RS_INVALID};
    directed_rows[4]  = {KIND_UNUSED_HI, 4'd9,  32'hFFFF_FFFF,  1'b1, 1'b1, RS_INVALID};
    directed_rows[5]  = {KIND_UNUSED_LO, 4'd3,  32'd7,          1'b0, 1'b1, RS_INVALID};
    directed_rows[6]  = {KIND_INIT,      4'd0,  32'd1,          1'b0, 1'b0, RS_OK};
    directed_rows[7]  = {KIND_INIT,      4'd15, 32'hFFFF_FFFF,  1'b1, 1'b0, RS_OK};
    directed_rows[8]  = {KIND_INIT,      4'd1,  32'd2,          1'b1, 1'b0, RS_OK};
    directed_rows[9]  = {KIND_START,     4'd0,  32'd0,          1'b0, 1'b0, RS_OK};
    directed_rows[10] = {KIND_START,     4'd0,  32'd0,          1'b0, 1'b1, RS_AGAIN};
    directed_rows[11] = {KIND_INIT,      4'd0,  32'd5,          1'b0, 1'b1, RS_AGAIN};
    directed_rows[12] = {KIND_DESTROY,   4'd0,  32'd0,          1'b0, 1'b1, RS_AGAIN};
    directed_rows[13] = {KIND_START,     4'd1,  32'd0,          1'b0, 1'b0, RS_OK};
    directed_rows[14] = {KIND_START,     4'd15, 32'd0,          1'b0, 1'b0, RS_OK};
    // one-shot slot 0 fires, slot 1 counts down
    directed_rows[15] = {KIND_TICK,      4'd10, 32'h5A5A_A5A5,  1'b1, 1'b0, RS_OK};
    // periodic slot 1 fires and re-arms
    directed_rows[16] = {KIND_TICK,      4'd5,  32'hA5A5_5A5A,  1'b0, 1'b0, RS_OK};
    directed_rows[17] = {KIND_STOP,      4'd1,  32'd0,          1'b0, 1'b0, RS_OK};
    directed_rows[18] = {KIND_STOP,      4'd1,  32'd0,          1'b0, 1'b1, RS_AGAIN};
    directed_rows[19] = {KIND_START,     4'd1,  32'd0,          1'b0, 1'b0, RS_OK};
    directed_rows[20] = {KIND_DESTROY,   4'd0,  32'd0,          1'b0, 1'b0, RS_OK};
    // tick with nothing expiring, then slot 1 again
    directed_rows[21] = {KIND_TICK,      4'd0,  32'd0,          1'b0, 1'b0, RS_OK};
    directed_rows[22] = {KIND_TICK,      4'd15, 32'hFFFF_FFFF,  1'b1, 1'b0, RS_OK};
    directed_rows[23] = {KIND_STOP,      4'd15, 32'd0,          1'b0, 1'b0, RS_OK};
    directed_rows[24] = {KIND_DESTROY,   4'd15, 32'd0,          1'b0, 1'b0, RS_OK};

    phase_max[0] = 32'd1;
    phase_max[1] = 32'd4;
    phase_max[2] = $urandom;
    phase_max[3] = 32'hFFFF_FFFF;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    drain_results();

    // random phases, each under its own register setting; phase 1 sends without gaps, phase 2 reads without stalls
    for (int p = 0; p < 4; p++) begin
      write_max_period(phase_max[p]);
      in_no_gaps    = (p == 1);
      out_no_stalls = (p == 2);
      run_random_phase(36);
      drain_results();
    end

    if (expected_events.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", expected_events.size());
    end
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/swtsm_pkg.sv
rtl/swtsm_cell.sv
rtl/software_timer_slot_manager.sv
sim/testbench.sv
